/* src/smrb_pkg.sv */
package smrb_pkg;

  // ring geometry, size is a power of two so pointers wrap by overflow
  localparam int RING_AW   = 8;
  localparam int RING_SIZE = 1 << RING_AW;

  // field widths
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 8;
  localparam int LIMIT_W = 7;
  localparam int CMP_W   = RING_AW + LEN_W;

  // message length cap, terminator included
  localparam int MAX_READ   = 64;
  localparam int MSG_CNT_W  = $clog2(MAX_READ);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(MAX_READ);

  // command queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [1:0] {
    KIND_MSG    = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2,
    KIND_EMPTY  = 2'd3
  } kind_t;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_READ  = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ADDR,
    BK_DATA
  } back_state_t;

  // classified request handed to the back end
  typedef struct packed {
    logic  is_read;
    kind_t kind;
  } cmd_t;

  // status from the back end seen by the front end
  typedef struct packed {
    logic               done;
    logic [RING_AW-1:0] rp;
  } back_stat_t;

endpackage

/* src/smrb_if.sv */
interface smrb_item_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;
  logic       first_of_chunk;
  logic [7:0] chunk_length;

  modport source (output valid, mode, data_byte, first_of_chunk, chunk_length,
                  input ready);
  modport sink (input valid, mode, data_byte, first_of_chunk, chunk_length,
                output ready);
endinterface

interface smrb_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] result_kind;
  logic       last;

  modport source (output valid, out_byte, result_kind, last, input ready);
  modport sink (input valid, out_byte, result_kind, last, output ready);
endinterface

/* src/smrb_ram.sv */
module smrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/smrb_front.sv */
module smrb_front
  import smrb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  smrb_item_if.sink          item,
  input  back_stat_t         bstat,
  input  logic               q_full,
  output logic               push,
  output cmd_t               push_cmd,
  output logic               wr_en,
  output logic [RING_AW-1:0] wr_addr,
  output logic [BYTE_W-1:0]  wr_data,
  output logic [RING_AW-1:0] wp
);

  logic               read_pending;
  logic               adm;
  logic               adm_next;
  logic [LEN_W-1:0]   rem;
  logic [LEN_W-1:0]   rem_next;
  logic [RING_AW-1:0] unread;
  logic [RING_AW-1:0] free_slots;
  logic               len_ok;
  logic               store;
  kind_t              wkind;
  logic               acc;
  logic               is_read;

  // hold off everything while a read is being carried out or the queue is full
  assign item.ready = !read_pending && !q_full;
  assign acc        = item.valid && item.ready;
  assign is_read    = (item.mode == MODE_READ);

  // room check, one slot always stays empty
  assign unread     = wp - bstat.rp;
  assign free_slots = ~unread;
  assign len_ok     = (item.chunk_length != '0) &&
                      (CMP_W'(item.chunk_length) <= CMP_W'(free_slots));

  // chunk admission
  always_comb begin
    store    = 1'b0;
    wkind    = KIND_REJECT;
    adm_next = adm;
    rem_next = rem;
    if (item.first_of_chunk) begin
      adm_next = 1'b0;
      rem_next = '0;
      if (len_ok) begin
        store    = 1'b1;
        wkind    = KIND_ACCEPT;
        rem_next = item.chunk_length - LEN_W'(1);
        adm_next = (rem_next != '0);
      end
    end else if (adm && rem != '0) begin
      store    = 1'b1;
      wkind    = KIND_ACCEPT;
      rem_next = rem - LEN_W'(1);
      adm_next = (rem_next != '0);
    end
  end

  // hand-off to queue and ring store
  assign push             = acc;
  assign push_cmd.is_read = is_read;
  assign push_cmd.kind    = is_read ? KIND_MSG : wkind;
  assign wr_en            = acc && !is_read && store;
  assign wr_addr          = wp;
  assign wr_data          = item.data_byte;

  // front state
  always_ff @(posedge clk) begin
    if (rst) begin
      wp           <= '0;
      adm          <= 1'b0;
      rem          <= '0;
      read_pending <= 1'b0;
    end else begin
      if (acc && !is_read) begin
        adm <= adm_next;
        rem <= rem_next;
        if (store) begin
          wp <= wp + RING_AW'(1);
        end
      end
      if (acc && is_read) begin
        read_pending <= 1'b1;
      end else if (bstat.done) begin
        read_pending <= 1'b0;
      end
    end
  end

endmodule

/* src/smrb_cmdq.sv */
module smrb_cmdq
  import smrb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t          slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == (Q_AW+1)'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (Q_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (Q_AW+1)'(1);
      end
    end
  end

endmodule

/* src/smrb_back.sv */
module smrb_back
  import smrb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  cmd_t               head_cmd,
  output logic               pop,
  input  logic [RING_AW-1:0] wp,
  input  logic [LIMIT_W-1:0] read_limit,
  output logic [RING_AW-1:0] rd_addr,
  input  logic [BYTE_W-1:0]  rd_data,
  output back_stat_t         bstat,
  smrb_result_if.source      result
);

  back_state_t            state;
  back_state_t            state_next;
  logic [RING_AW-1:0]     rp;
  logic [RING_AW-1:0]     rp_next;
  logic [MSG_CNT_W-1:0]   n;
  logic [MSG_CNT_W-1:0]   n_next;
  logic [MSG_CNT_W-1:0]   lim_m1;
  logic [MSG_CNT_W-1:0]   lim_m1_next;
  logic [MSG_CNT_W-1:0]   lim_clamped;
  logic                   slot_free;
  logic                   emit;
  logic [BYTE_W-1:0]      e_byte;
  kind_t                  e_kind;
  logic                   e_last;
  logic                   done;
  logic                   oval;
  logic [BYTE_W-1:0]      obyte;
  kind_t                  okind;
  logic                   olast;

  // limit minus one, zero acts as one and anything above the cap as the cap
  always_comb begin
    if (read_limit == '0) begin
      lim_clamped = '0;
    end else if (read_limit > LIMIT_W'(MAX_READ)) begin
      lim_clamped = MSG_CNT_W'(MAX_READ - 1);
    end else begin
      lim_clamped = MSG_CNT_W'(read_limit - LIMIT_W'(1));
    end
  end

  assign slot_free = !oval || result.ready;
  assign rd_addr   = rp;

  // sequencer: one step per queued write or empty read; each message byte goes through BK_ADDR then BK_DATA
  always_comb begin
    state_next  = state;
    rp_next     = rp;
    n_next      = n;
    lim_m1_next = lim_m1;
    pop         = 1'b0;
    emit        = 1'b0;
    e_byte      = '0;
    e_kind      = KIND_MSG;
    e_last      = 1'b1;
    done        = 1'b0;
    case (state)
      BK_IDLE: begin
        if (head_valid) begin
          if (!head_cmd.is_read) begin
            if (slot_free) begin
              emit   = 1'b1;
              e_kind = head_cmd.kind;
              pop    = 1'b1;
            end
          end else if (rp == wp) begin
            if (slot_free) begin
              emit   = 1'b1;
              e_kind = KIND_EMPTY;
              pop    = 1'b1;
              done   = 1'b1;
            end
          end else begin
            pop         = 1'b1;
            n_next      = '0;
            lim_m1_next = lim_clamped;
            state_next  = BK_ADDR;
          end
        end
      end
      BK_ADDR: begin
        // ram read of rp in flight
        state_next = BK_DATA;
      end
      BK_DATA: begin
        if (slot_free) begin
          emit    = 1'b1;
          rp_next = rp + RING_AW'(1);
          if (n != lim_m1 && rd_data != '0) begin
            e_byte     = rd_data;
            e_last     = 1'b0;
            n_next     = n + MSG_CNT_W'(1);
            state_next = BK_ADDR;
          end else begin
            done       = 1'b1;
            state_next = BK_IDLE;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      rp    <= '0;
    end else begin
      state <= state_next;
      rp    <= rp_next;
    end
  end

  always_ff @(posedge clk) begin
    n      <= n_next;
    lim_m1 <= lim_m1_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      oval <= 1'b0;
    end else if (slot_free) begin
      oval <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && emit) begin
      obyte <= e_byte;
      okind <= e_kind;
      olast <= e_last;
    end
  end

  assign result.valid       = oval;
  assign result.out_byte    = obyte;
  assign result.result_kind = okind;
  assign result.last        = olast;

  assign bstat.done = done;
  assign bstat.rp   = rp;

endmodule

/* src/string_message_ring_buffer.sv */
// channel | dir | fields                                          | handshake
// item    | in  | mode, data_byte, first_of_chunk, chunk_length  | valid/ready
// result  | out | out_byte, result_kind, last                     | valid/ready
// cfg     | in  | cfg_wr_data (read_limit)                        | cfg_wr_en
//
// a write byte yields one result; writes stream back to back while the queue has room
// a read fetches each emitted byte through the registered read of the ring store;
// the front takes no item until it finishes
// rst is synchronous and clears pointers, chunk tracking, queue and output
// valid; the ring store needs no clearing
// a stalled result holds in the output register while the queue keeps filling
module string_message_ring_buffer
  import smrb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  smrb_item_if.sink            item,
  smrb_result_if.source        result,
  input  logic                 cfg_wr_en,
  input  logic [LIMIT_W-1:0]   cfg_wr_data
);

  logic [LIMIT_W-1:0] read_limit;
  back_stat_t         bstat;
  logic               push;
  cmd_t               push_cmd;
  logic               q_full;
  logic               pop;
  logic               head_valid;
  cmd_t               head_cmd;
  logic               wr_en;
  logic [RING_AW-1:0] wr_addr;
  logic [BYTE_W-1:0]  wr_data;
  logic [RING_AW-1:0] rd_addr;
  logic [BYTE_W-1:0]  rd_data;
  logic [RING_AW-1:0] wp;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      read_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      read_limit <= cfg_wr_data;
    end
  end

  smrb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .bstat    (bstat),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .wp       (wp)
  );

  smrb_cmdq u_cmdq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  smrb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_SIZE)
  ) u_ring (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  smrb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .wp         (wp),
    .read_limit (read_limit),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .bstat      (bstat),
    .result     (result)
  );

endmodule

/* src/smrb_checker.sv */
module smrb_checker
  import smrb_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_mode,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [1:0] out_kind,
  input logic       out_last
);

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_kind) && $stable(out_last))
    else $error("stalled result changed");

  // write and empty results are single and closing
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != KIND_MSG |-> out_last)
    else $error("non-message result without last");

  // message bytes before the terminator are never zero
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_MSG && !out_last |-> out_byte != 8'd0)
    else $error("zero message byte before terminator");

  // a read request blocks the input until it is done
  a_read_block: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_mode == MODE_READ |=> !in_ready)
    else $error("input open while read in progress");

endmodule

bind string_message_ring_buffer smrb_checker u_smrb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .in_mode   (item.mode),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_byte  (result.out_byte),
  .out_kind  (result.result_kind),
  .out_last  (result.last)
);
